// File: sv/keyed_backoff_throttle_table_macros.svh
// Assertion macros shared by the throttle table RTL.
`ifndef KEYED_BACKOFF_THROTTLE_TABLE_MACROS_SVH
`define KEYED_BACKOFF_THROTTLE_TABLE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define KBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kbt_pkg.sv
// Package with the types, codes and constants of the throttle table.
package kbt_pkg;

    localparam int DEF_TABLE_CAPACITY = 64;
    localparam int FAIL_SAT           = 1000;
    localparam int SHIFT_CAP          = 20;
    localparam int DEF_THRESHOLD      = 5;
    localparam int DEF_MAX_WAIT       = 300;

    localparam int THR_W      = 10;
    localparam int MW_W       = 16;
    localparam int TAG_W      = 32;
    localparam int KEY_W      = TAG_W + 1;
    localparam int FAIL_W     = 10;
    localparam int TIME_W     = 32;
    localparam int WAIT_W     = 16;
    localparam int USE_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_QUERY   = 2'd0;
    localparam logic [1:0] CMD_FAIL    = 2'd1;
    localparam logic [1:0] CMD_SUCCESS = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT  = 1'd1;

    typedef struct packed {
        logic [1:0]        command;
        logic              account_valid;
        logic [TAG_W-1:0]  account_tag;
        logic              address_valid;
        logic [TAG_W-1:0]  address_tag;
        logic [TIME_W-1:0] now_seconds;
    } req_word_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_seconds;
        logic [USE_W-1:0]  entries_in_use;
    } rsp_word_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [FAIL_W-1:0] failures;
        logic [TIME_W-1:0] last_time;
    } entry_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_seconds;
        logic              expired;
    } wait_info_t;

endpackage

// File: sv/kbt_mem.sv
// Entry memory: one write port and one read port with registered read data.
module kbt_mem #(
    parameter int DEPTH = kbt_pkg::DEF_TABLE_CAPACITY + 2,
    parameter int AW    = $clog2(kbt_pkg::DEF_TABLE_CAPACITY + 2)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  kbt_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output kbt_pkg::entry_t rdata
);
    import kbt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/kbt_wait.sv
// Backoff wait and expiry of one entry at the current time.
module kbt_wait (
    input  logic [kbt_pkg::THR_W-1:0]  threshold,
    input  logic [kbt_pkg::MW_W-1:0]   max_wait,
    input  logic [kbt_pkg::FAIL_W-1:0] failures,
    input  logic [kbt_pkg::TIME_W-1:0] last_time,
    input  logic [kbt_pkg::TIME_W-1:0] now,
    output kbt_pkg::wait_info_t        info
);
    import kbt_pkg::*;

    logic [THR_W-1:0]  th;
    logic [MW_W-1:0]   mw;
    logic [FAIL_W-1:0] over;
    logic [4:0]        sh;
    logic [18:0]       pow;
    logic [MW_W-1:0]   window;
    logic [TIME_W-1:0] el;

    always_comb
    begin
        th   = (threshold == '0) ? THR_W'(DEF_THRESHOLD) : threshold;
        mw   = (max_wait == '0) ? MW_W'(DEF_MAX_WAIT) : max_wait;
        over = failures - th;
        sh   = 5'(over - FAIL_W'(1));
        pow  = 19'(1) << sh;
        if (over >= FAIL_W'(SHIFT_CAP) || pow > {3'b0, mw})
        begin
            window = mw;
        end
        else
        begin
            window = pow[MW_W-1:0];
        end
        el = (now >= last_time) ? now - last_time : '0;
        if (failures <= th || el >= {16'b0, window})
        begin
            info.wait_seconds = '0;
        end
        else
        begin
            info.wait_seconds = window - el[MW_W-1:0];
        end
        // Expired: no wait left and the last failure lies over max_wait back.
        info.expired = (info.wait_seconds == '0) && (el > {16'b0, mw});
    end

endmodule

// File: sv/keyed_backoff_throttle_table.sv
// Top level of the keyed exponential backoff throttle table.
`include "keyed_backoff_throttle_table_macros.svh"

// The block keeps up to TABLE_CAPACITY+2 throttled keys (account or address
// tags) in one on-chip memory with a registered read, and handles one request
// word at a time by sweeping that memory. A failure that pushes the table over
// capacity adds an expiry sweep and then, for each entry that must still go to
// bring the count down to TABLE_CAPACITY/2, one sweep that picks the oldest
// entry. After reset the block runs a clearing pass over every slot before it
// takes its first request word. The response word sits in an output register,
// so a new request is taken while it waits. Register writes are expected only
// while the block is idle.
module keyed_backoff_throttle_table #(
    parameter int TABLE_CAPACITY = kbt_pkg::DEF_TABLE_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  kbt_pkg::req_word_t               req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output kbt_pkg::rsp_word_t               rsp,
    input  logic                             cfg_write,
    input  logic [kbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import kbt_pkg::*;

    localparam int DEPTH = TABLE_CAPACITY + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int HALF  = TABLE_CAPACITY / 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);
    localparam logic [CW-1:0] CAP_C   = CW'(TABLE_CAPACITY);
    localparam logic [CW-1:0] HALF1_C = CW'(HALF + 1);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_FAILWR0 = 4'd3;
    localparam logic [3:0] S_FAILWR1 = 4'd4;
    localparam logic [3:0] S_EVSCAN  = 4'd5;
    localparam logic [3:0] S_MINSCAN = 4'd6;
    localparam logic [3:0] S_MINDROP = 4'd7;
    localparam logic [3:0] S_WIPE    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]        state_reg, state_next;
    req_word_t         req_reg, req_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              p_vld_reg, p_vld_next;
    logic [AW-1:0]     p_addr_reg, p_addr_next;
    logic [WAIT_W-1:0] wait_max_reg, wait_max_next;
    logic              hit0_reg, hit0_next, hit1_reg, hit1_next;
    logic [AW-1:0]     idx0_reg, idx0_next, idx1_reg, idx1_next;
    logic [FAIL_W-1:0] f0_reg, f0_next, f1_reg, f1_next;
    logic              free0_ok_reg, free0_ok_next, free1_ok_reg, free1_ok_next;
    logic [AW-1:0]     free0_reg, free0_next, free1_reg, free1_next;
    logic              used0_reg, used0_next;
    logic              best_ok_reg, best_ok_next;
    logic [AW-1:0]     best_reg, best_next;
    logic [TIME_W+KEY_W-1:0] best_lk_reg, best_lk_next;
    logic [THR_W-1:0]  thr_reg;
    logic [MW_W-1:0]   mw_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_reg, rsp_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    entry_t            mem_wdata, ent;
    wait_info_t        winfo;
    logic [KEY_W-1:0]  key0, key1;
    logic              m0, m1, scan_done;
    logic [TIME_W+KEY_W-1:0] ent_lk;
    logic [CW+USE_W-1:0] cnt_ext;

    kbt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (ent)
    );

    kbt_wait u_wait (
        .threshold (thr_reg),
        .max_wait  (mw_reg),
        .failures  (ent.failures),
        .last_time (ent.last_time),
        .now       (req_reg.now_seconds),
        .info      (winfo)
    );

    assign key0      = {1'b1, req_reg.account_tag};
    assign key1      = {1'b0, req_reg.address_tag};
    assign m0        = req_reg.account_valid && ent.valid && (ent.key == key0);
    assign m1        = req_reg.address_valid && ent.valid && (ent.key == key1);
    assign scan_done = (scan_reg == DEPTH_C) && !p_vld_reg;
    assign ent_lk    = {ent.last_time, ent.key};
    assign cnt_ext   = {{USE_W{1'b0}}, cnt_reg};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        wait_max_next  = wait_max_reg;
        hit0_next      = hit0_reg;
        hit1_next      = hit1_reg;
        idx0_next      = idx0_reg;
        idx1_next      = idx1_reg;
        f0_next        = f0_reg;
        f1_next        = f1_reg;
        free0_ok_next  = free0_ok_reg;
        free1_ok_next  = free1_ok_reg;
        free0_next     = free0_reg;
        free1_next     = free1_reg;
        used0_next     = used0_reg;
        best_ok_next   = best_ok_reg;
        best_next      = best_reg;
        best_lk_next   = best_lk_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = p_addr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = scan_reg[AW-1:0];

        // Read issue for the sweeping states; data is registered and comes back in the next cycle.
        if ((state_reg == S_SCAN || state_reg == S_EVSCAN || state_reg == S_MINSCAN)
            && scan_reg < DEPTH_C)
        begin
            mem_re    = 1'b1;
            scan_next = scan_reg + CW'(1);
        end
        p_vld_next  = mem_re;
        p_addr_next = mem_raddr;

        case (state_reg)
            S_INIT, S_WIPE:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg[AW-1:0];
                scan_next = scan_reg + CW'(1);
                if (scan_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_WIPE) ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    scan_next     = '0;
                    wait_max_next = '0;
                    hit0_next     = 1'b0;
                    hit1_next     = 1'b0;
                    free0_ok_next = 1'b0;
                    free1_ok_next = 1'b0;
                    used0_next    = 1'b0;
                    state_next    = (req.command == CMD_CLEAR) ? S_WIPE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (p_vld_reg)
                begin
                    case (req_reg.command)
                        CMD_QUERY:
                        begin
                            if ((m0 || m1) && winfo.wait_seconds > wait_max_reg)
                            begin
                                wait_max_next = winfo.wait_seconds;
                            end
                        end
                        CMD_FAIL:
                        begin
                            if (m0)
                            begin
                                hit0_next = 1'b1;
                                idx0_next = p_addr_reg;
                                f0_next   = ent.failures;
                            end
                            if (m1)
                            begin
                                hit1_next = 1'b1;
                                idx1_next = p_addr_reg;
                                f1_next   = ent.failures;
                            end
                            if (!ent.valid)
                            begin
                                if (!free0_ok_reg)
                                begin
                                    free0_ok_next = 1'b1;
                                    free0_next    = p_addr_reg;
                                end
                                else if (!free1_ok_reg)
                                begin
                                    free1_ok_next = 1'b1;
                                    free1_next    = p_addr_reg;
                                end
                            end
                        end
                        CMD_SUCCESS:
                        begin
                            if (m0 || m1)
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (scan_done)
                begin
                    state_next = (req_reg.command == CMD_FAIL) ? S_FAILWR0 : S_OUT;
                end
            end
            S_FAILWR0:
            begin
                mem_wdata.valid     = 1'b1;
                mem_wdata.key       = key0;
                mem_wdata.last_time = req_reg.now_seconds;
                if (req_reg.account_valid)
                begin
                    if (hit0_reg)
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = idx0_reg;
                        mem_wdata.failures = (f0_reg < FAIL_W'(FAIL_SAT)) ?
                                             f0_reg + FAIL_W'(1) : f0_reg;
                    end
                    else if (free0_ok_reg)
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = free0_reg;
                        mem_wdata.failures = FAIL_W'(1);
                        cnt_next           = cnt_reg + CW'(1);
                        used0_next         = 1'b1;
                    end
                end
                state_next = S_FAILWR1;
            end
            S_FAILWR1:
            begin
                mem_wdata.valid     = 1'b1;
                mem_wdata.key       = key1;
                mem_wdata.last_time = req_reg.now_seconds;
                mem_wdata.failures  = FAIL_W'(1);
                if (req_reg.address_valid)
                begin
                    if (hit1_reg)
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = idx1_reg;
                        mem_wdata.failures = (f1_reg < FAIL_W'(FAIL_SAT)) ?
                                             f1_reg + FAIL_W'(1) : f1_reg;
                    end
                    else if (!used0_reg && free0_ok_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free0_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else if (used0_reg && free1_ok_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free1_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end
                scan_next  = '0;
                state_next = (cnt_next > CAP_C) ? S_EVSCAN : S_OUT;
            end
            S_EVSCAN:
            begin
                if (p_vld_reg && ent.valid && winfo.expired)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
                if (scan_done)
                begin
                    scan_next    = '0;
                    best_ok_next = 1'b0;
                    state_next   = (cnt_reg > CAP_C) ? S_MINSCAN : S_OUT;
                end
            end
            S_MINSCAN:
            begin
                if (p_vld_reg && ent.valid && (!best_ok_reg || ent_lk < best_lk_reg))
                begin
                    best_ok_next = 1'b1;
                    best_next    = p_addr_reg;
                    best_lk_next = ent_lk;
                end
                if (scan_done)
                begin
                    state_next = S_MINDROP;
                end
            end
            S_MINDROP:
            begin
                scan_next    = '0;
                best_ok_next = 1'b0;
                state_next   = S_OUT;
                if (best_ok_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = best_reg;
                    cnt_next  = cnt_reg - CW'(1);
                    if (cnt_reg > HALF1_C)
                    begin
                        state_next = S_MINSCAN;
                    end
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.wait_seconds   = (req_reg.command == CMD_QUERY) ?
                                              wait_max_reg : '0;
                    rsp_next.entries_in_use = cnt_ext[USE_W-1:0];
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            p_vld_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            thr_reg       <= THR_W'(DEF_THRESHOLD);
            mw_reg        <= MW_W'(DEF_MAX_WAIT);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            p_vld_reg     <= p_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    REG_MAX_WAIT:  mw_reg  <= cfg_data[MW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        p_addr_reg   <= p_addr_next;
        wait_max_reg <= wait_max_next;
        hit0_reg     <= hit0_next;
        hit1_reg     <= hit1_next;
        idx0_reg     <= idx0_next;
        idx1_reg     <= idx1_next;
        f0_reg       <= f0_next;
        f1_reg       <= f1_next;
        free0_ok_reg <= free0_ok_next;
        free1_ok_reg <= free1_ok_next;
        free0_reg    <= free0_next;
        free1_reg    <= free1_next;
        used0_reg    <= used0_next;
        best_ok_reg  <= best_ok_next;
        best_reg     <= best_next;
        best_lk_reg  <= best_lk_next;
        rsp_reg      <= rsp_next;
    end

    // The entry count never exceeds the number of slots.
    `KBT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= DEPTH_C, "entry count above depth")
    // The table is never written while the block waits for a request word.
    `KBT_ASSERT_NOW(a_idle_no_write, state_reg == S_IDLE, !mem_we, "write while idle")
    // No read data is pending once the block is back in idle.
    `KBT_ASSERT_NOW(a_idle_no_read, state_reg == S_IDLE, !p_vld_reg, "read pending in idle")
    // Each oldest-entry drop removes exactly one entry.
    `KBT_ASSERT_NEXT(a_drop_one, state_reg == S_MINDROP && best_ok_reg,
                     cnt_reg == $past(cnt_reg) - CW'(1), "drop did not remove one entry")

endmodule
